// ===== hdl/pvst_pkg.sv =====
package pvst_pkg;

    localparam int SIZE_WIDTH = 20;
    localparam int FRAC_WIDTH = 16;
    // radial vector of the cylinder; covers |r - round(m*a)| for any cylinder request
    localparam int RAD_WIDTH = 24;
    localparam logic [FRAC_WIDTH-1:0] TOL_FRAC_RESET = 16'd1311;

    typedef enum logic [2:0] {
        KIND_BOX    = 3'd0,
        KIND_CYL    = 3'd1,
        KIND_SPHERE = 3'd2,
        KIND_WALL   = 3'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  flat;
    } t_ctl;

    typedef struct packed {
        logic box_hit;
        logic wall_hit;
        logic sph_hit;
        logic in_len;
        logic flat_end;
    } t_flags;

endpackage

// ===== hdl/pvst_req_if.sv =====
interface pvst_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  volume_kind;
    logic        point_is_relative;
    logic        is_flat_ended;
    logic [62:0] point_xyz;
    logic [62:0] centre_xyz;
    logic [62:0] axis_one_xyz;
    logic [62:0] axis_two_xyz;
    logic [62:0] axis_three_xyz;
    logic [59:0] half_extents;
    logic [19:0] tube_radius;
    logic [19:0] bounding_radius;

    modport source (output valid, volume_kind, point_is_relative, is_flat_ended, point_xyz,
                    centre_xyz, axis_one_xyz, axis_two_xyz, axis_three_xyz, half_extents,
                    tube_radius, bounding_radius, input ready);
    modport sink (input valid, volume_kind, point_is_relative, is_flat_ended, point_xyz,
                  centre_xyz, axis_one_xyz, axis_two_xyz, axis_three_xyz, half_extents,
                  tube_radius, bounding_radius, output ready);
endinterface

// ===== hdl/pvst_rsp_if.sv =====
interface pvst_rsp_if;
    logic valid;
    logic ready;
    logic on_surface;

    modport source (output valid, on_surface, input ready);
    modport sink (input valid, on_surface, output ready);
endinterface

// ===== hdl/pvst_cfg_if.sv =====
interface pvst_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] tolerance_fraction;

    modport source (output valid, tolerance_fraction, input ready);
    modport sink (input valid, tolerance_fraction, output ready);
endinterface

// ===== hdl/pvst_proj.sv =====
// Stages B and C: axis products, projections, squared radii.
module pvst_proj #(
    parameter int W = 21,
    parameter int F = 19
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  pvst_pkg::t_ctl         i_ctl,
    input  logic signed [W:0]      i_r [3],
    input  logic signed [F+1:0]    i_a [3][3],
    input  logic [19:0]            i_len [3],
    input  logic [19:0]            i_tol,
    input  logic [19:0]            i_rad,
    input  logic [19:0]            i_brad,
    output logic                   o_vld,
    output pvst_pkg::t_ctl         o_ctl,
    output logic signed [W+4:0]    o_f [3],
    output logic signed [W:0]      o_r [3],
    output logic signed [F+1:0]    o_a0 [3],
    output logic [20:0]            o_lentol [3],
    output logic [19:0]            o_len0,
    output logic [19:0]            o_tol,
    output logic [2*W+3:0]         o_d2s,
    output logic [41:0]            o_hic2,
    output logic [39:0]            o_loc2,
    output logic                   o_lopos_c,
    output logic [41:0]            o_his2,
    output logic [39:0]            o_los2,
    output logic                   o_lopos_s
);
    import pvst_pkg::*;

    localparam int A  = F + 2;
    localparam int PW = W + A + 1;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HALF = SW'(2 ** (F - 1));

    // stage B
    logic                 r_vb;
    t_ctl                 r_ctl_b;
    logic signed [PW-1:0] r_pr [3][3];
    logic [2*W+1:0]       r_rsq [3];
    logic signed [W:0]    r_r_b [3];
    logic signed [A-1:0]  r_a0_b [3];
    logic [20:0]          r_lentol_b [3];
    logic [19:0]          r_len0_b;
    logic [19:0]          r_tol_b;
    logic [20:0]          r_hic, r_his;
    logic signed [21:0]   r_loc, r_los;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_vb <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl_b <= i_ctl;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pr[i][k] <= PW'(i_a[i][k]) * PW'(i_r[k]);
                end
                r_rsq[i]      <= (2*W+2)'(i_r[i]) * (2*W+2)'(i_r[i]);
                r_r_b[i]      <= i_r[i];
                r_a0_b[i]     <= i_a[0][i];
                r_lentol_b[i] <= 21'(i_len[i]) + 21'(i_tol);
            end
            r_len0_b <= i_len[0];
            r_tol_b  <= i_tol;
            r_hic    <= 21'(i_rad) + 21'(i_tol);
            r_his    <= 21'(i_brad) + 21'(i_tol);
            r_loc    <= $signed(22'(i_rad)) - $signed(22'(i_tol));
            r_los    <= $signed(22'(i_brad)) - $signed(22'(i_tol));
        end
    end

    // stage C
    logic signed [SW-1:0] sum [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = SW'(r_pr[i][0]) + SW'(r_pr[i][1]) + SW'(r_pr[i][2]) + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl <= r_ctl_b;
            for (int i = 0; i < 3; i++) begin
                o_f[i]      <= (W+5)'(sum[i] >>> F);
                o_r[i]      <= r_r_b[i];
                o_a0[i]     <= r_a0_b[i];
                o_lentol[i] <= r_lentol_b[i];
            end
            o_len0    <= r_len0_b;
            o_tol     <= r_tol_b;
            o_d2s     <= (2*W+4)'(r_rsq[0]) + (2*W+4)'(r_rsq[1]) + (2*W+4)'(r_rsq[2]);
            o_hic2    <= 42'(r_hic) * 42'(r_hic);
            o_his2    <= 42'(r_his) * 42'(r_his);
            o_loc2    <= 40'(r_loc[19:0]) * 40'(r_loc[19:0]);
            o_los2    <= 40'(r_los[19:0]) * 40'(r_los[19:0]);
            o_lopos_c <= (r_loc > 22'sd0);
            o_lopos_s <= (r_los > 22'sd0);
        end
    end

endmodule

// ===== hdl/pvst_radial.sv =====
// Stages D, E, F: band decisions, radial vector of the cylinder, its squares.
module pvst_radial #(
    parameter int W = 21,
    parameter int F = 19
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  pvst_pkg::t_ctl         i_ctl,
    input  logic signed [W+4:0]    i_f [3],
    input  logic signed [W:0]      i_r [3],
    input  logic signed [F+1:0]    i_a0 [3],
    input  logic [20:0]            i_lentol [3],
    input  logic [19:0]            i_len0,
    input  logic [19:0]            i_tol,
    input  logic [2*W+3:0]         i_d2s,
    input  logic [41:0]            i_hic2,
    input  logic [39:0]            i_loc2,
    input  logic                   i_lopos_c,
    input  logic [41:0]            i_his2,
    input  logic [39:0]            i_los2,
    input  logic                   i_lopos_s,
    output logic                   o_vld,
    output pvst_pkg::t_ctl         o_ctl,
    output pvst_pkg::t_flags       o_flags,
    output logic [41:0]            o_hic2,
    output logic [39:0]            o_loc2,
    output logic                   o_lopos_c,
    output logic signed [2*pvst_pkg::RAD_WIDTH-1:0] o_vsq [3]
);
    import pvst_pkg::*;

    localparam int A   = F + 2;
    localparam int FW  = W + 5;
    localparam int MW  = (FW > 21) ? FW : 21;
    localparam int CW  = MW + 2;
    localparam int QW  = MW + A;
    localparam int VW  = RAD_WIDTH;
    localparam int DW  = (2*W + 4 > 42) ? 2*W + 4 : 42;
    localparam logic signed [QW-1:0] HALF = QW'(2 ** (F - 1));

    // stage D
    logic signed [CW-1:0] af [3];
    logic signed [CW-1:0] ln0, tl, dend;
    logic signed [MW-1:0] m;
    logic [2:0]           box_i;
    t_flags               flg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            af[i] = i_f[i][FW-1] ? -CW'(i_f[i]) : CW'(i_f[i]);
        end
        ln0  = CW'(i_len0);
        tl   = CW'(i_tol);
        dend = (af[0] > ln0) ? af[0] - ln0 : ln0 - af[0];
        box_i = '0;
        for (int i = 0; i < 3; i++) begin
            logic signed [CW-1:0] li, di;
            li = CW'(i_lentol[i]) - tl;
            di = (af[i] > li) ? af[i] - li : li - af[i];
            box_i[i] = (di < tl)
                    && (af[(i+1)%3] < CW'(i_lentol[(i+1)%3]))
                    && (af[(i+2)%3] < CW'(i_lentol[(i+2)%3]));
        end
        flg.box_hit  = |box_i;
        flg.wall_hit = (af[0] < tl);
        flg.sph_hit  = (DW'(i_d2s) < DW'(i_his2)) &&
                       (!i_lopos_s || (DW'(i_d2s) > DW'(i_los2)));
        flg.in_len   = (af[0] < CW'(i_lentol[0]));
        flg.flat_end = (dend < tl);
        // within the length: drop f onto the axis; beyond: nearer end centre
        if (flg.in_len) begin
            m = MW'(i_f[0]);
        end else if (i_f[0] > FW'(0)) begin
            m = MW'(i_len0);
        end else begin
            m = -MW'(i_len0);
        end
    end

    logic                 r_vd;
    t_ctl                 r_ctl_d;
    t_flags               r_flg_d;
    logic signed [QW-1:0] r_q [3];
    logic signed [W:0]    r_r_d [3];
    logic [41:0]          r_hic2_d;
    logic [39:0]          r_loc2_d;
    logic                 r_lopos_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_vd <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl_d <= i_ctl;
            r_flg_d <= flg;
            for (int k = 0; k < 3; k++) begin
                r_q[k]   <= QW'(m) * QW'(i_a0[k]);
                r_r_d[k] <= i_r[k];
            end
            r_hic2_d  <= i_hic2;
            r_loc2_d  <= i_loc2;
            r_lopos_d <= i_lopos_c;
        end
    end

    // stage E
    logic                 r_ve;
    t_ctl                 r_ctl_e;
    t_flags               r_flg_e;
    logic signed [VW-1:0] r_v [3];
    logic [41:0]          r_hic2_e;
    logic [39:0]          r_loc2_e;
    logic                 r_lopos_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (i_en) begin
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl_e <= r_ctl_d;
            r_flg_e <= r_flg_d;
            for (int k = 0; k < 3; k++) begin
                r_v[k] <= VW'(r_r_d[k]) - VW'((r_q[k] + HALF) >>> F);
            end
            r_hic2_e  <= r_hic2_d;
            r_loc2_e  <= r_loc2_d;
            r_lopos_e <= r_lopos_d;
        end
    end

    // stage F
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl   <= r_ctl_e;
            o_flags <= r_flg_e;
            for (int k = 0; k < 3; k++) begin
                o_vsq[k] <= (2*VW)'(r_v[k]) * (2*VW)'(r_v[k]);
            end
            o_hic2    <= r_hic2_e;
            o_loc2    <= r_loc2_e;
            o_lopos_c <= r_lopos_e;
        end
    end

endmodule

// ===== hdl/point_on_volume_surface_test_core.sv =====
// Point-on-surface test for one collision volume (box, cylinder/capsule, sphere,
// wall). Each request is a point plus a volume description; each yields one
// on_surface flag. Seven register stages (input capture, axis products,
// projections, band decisions and radial product, radial vector, squares,
// output register): one request per cycle sustained while responses are taken.
// The pipeline advances as one unit whenever the output register is empty or
// being taken, so ready drops only while a response is held. The tolerance
// register is written through the config channel, which is always ready; write
// it only while idle.
module point_on_volume_surface_test_core #(
    parameter int COORD_WIDTH    = 21,
    parameter int AXIS_FRAC_BITS = 19
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pvst_req_if.sink    i_req,
    pvst_rsp_if.source  o_rsp,
    pvst_cfg_if.sink    i_cfg
);
    import pvst_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = AXIS_FRAC_BITS;
    localparam int A   = F + 2;
    localparam int VW  = RAD_WIDTH;
    localparam int DW  = 2*VW + 2;

    logic [FRAC_WIDTH-1:0] r_tol_frac;
    logic                  en;

    // config register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_frac <= TOL_FRAC_RESET;
        end else if (i_cfg.valid) begin
            r_tol_frac <= i_cfg.tolerance_fraction;
        end
    end

    // global advance: output slot free or being drained
    assign en          = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = en;

    // stage A: centre subtraction (skipped for a relative point), tolerance
    logic signed [W-1:0] pt, ct;
    logic signed [W:0]   n_r [3];
    logic signed [A-1:0] n_a [3][3];
    logic [19:0]         n_tol;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pt = $signed(i_req.point_xyz[k*W +: W]);
            ct = $signed(i_req.centre_xyz[k*W +: W]);
            n_r[k] = i_req.point_is_relative ? (W+1)'(pt) : (W+1)'(pt) - (W+1)'(ct);
            n_a[0][k] = $signed(i_req.axis_one_xyz[k*A +: A]);
            n_a[1][k] = $signed(i_req.axis_two_xyz[k*A +: A]);
            n_a[2][k] = $signed(i_req.axis_three_xyz[k*A +: A]);
        end
        n_tol = 20'((36'(i_req.bounding_radius) * 36'(r_tol_frac)) >> FRAC_WIDTH);
    end

    logic                r_va;
    t_ctl                r_ctl_a;
    logic signed [W:0]   r_r_a [3];
    logic signed [A-1:0] r_a_a [3][3];
    logic [19:0]         r_len_a [3];
    logic [19:0]         r_tol_a, r_rad_a, r_brad_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl_a.kind <= t_kind'(i_req.volume_kind);
            r_ctl_a.flat <= i_req.is_flat_ended;
            r_r_a        <= n_r;
            r_a_a        <= n_a;
            for (int k = 0; k < 3; k++) begin
                r_len_a[k] <= i_req.half_extents[k*SIZE_WIDTH +: SIZE_WIDTH];
            end
            r_tol_a  <= n_tol;
            r_rad_a  <= i_req.tube_radius;
            r_brad_a <= i_req.bounding_radius;
        end
    end

    // stages B, C
    logic                vc;
    t_ctl                ctl_c;
    logic signed [W+4:0] f_c [3];
    logic signed [W:0]   r_c [3];
    logic signed [A-1:0] a0_c [3];
    logic [20:0]         lentol_c [3];
    logic [19:0]         len0_c, tol_c;
    logic [2*W+3:0]      d2s_c;
    logic [41:0]         hic2_c, his2_c;
    logic [39:0]         loc2_c, los2_c;
    logic                lopos_c_c, lopos_s_c;

    pvst_proj #(.W(W), .F(F)) u_proj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (r_va),
        .i_ctl     (r_ctl_a),
        .i_r       (r_r_a),
        .i_a       (r_a_a),
        .i_len     (r_len_a),
        .i_tol     (r_tol_a),
        .i_rad     (r_rad_a),
        .i_brad    (r_brad_a),
        .o_vld     (vc),
        .o_ctl     (ctl_c),
        .o_f       (f_c),
        .o_r       (r_c),
        .o_a0      (a0_c),
        .o_lentol  (lentol_c),
        .o_len0    (len0_c),
        .o_tol     (tol_c),
        .o_d2s     (d2s_c),
        .o_hic2    (hic2_c),
        .o_loc2    (loc2_c),
        .o_lopos_c (lopos_c_c),
        .o_his2    (his2_c),
        .o_los2    (los2_c),
        .o_lopos_s (lopos_s_c)
    );

    // stages D, E, F
    logic                  vf;
    t_ctl                  ctl_f;
    t_flags                flg_f;
    logic [41:0]           hic2_f;
    logic [39:0]           loc2_f;
    logic                  lopos_f;
    logic signed [2*VW-1:0] vsq_f [3];

    pvst_radial #(.W(W), .F(F)) u_radial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (vc),
        .i_ctl     (ctl_c),
        .i_f       (f_c),
        .i_r       (r_c),
        .i_a0      (a0_c),
        .i_lentol  (lentol_c),
        .i_len0    (len0_c),
        .i_tol     (tol_c),
        .i_d2s     (d2s_c),
        .i_hic2    (hic2_c),
        .i_loc2    (loc2_c),
        .i_lopos_c (lopos_c_c),
        .i_his2    (his2_c),
        .i_los2    (los2_c),
        .i_lopos_s (lopos_s_c),
        .o_vld     (vf),
        .o_ctl     (ctl_f),
        .o_flags   (flg_f),
        .o_hic2    (hic2_f),
        .o_loc2    (loc2_f),
        .o_lopos_c (lopos_f),
        .o_vsq     (vsq_f)
    );

    // stage G: radial distance against the band, final select
    logic [DW-1:0] d2;
    logic          below_hi, band, cyl_hit, n_hit;

    always_comb begin
        d2       = DW'(vsq_f[0]) + DW'(vsq_f[1]) + DW'(vsq_f[2]);
        below_hi = d2 < DW'(hic2_f);
        band     = below_hi && (!lopos_f || (d2 > DW'(loc2_f)));
        if (flg_f.in_len) begin
            cyl_hit = (ctl_f.flat && flg_f.flat_end && below_hi) || band;
        end else begin
            cyl_hit = !ctl_f.flat && band;
        end
        case (ctl_f.kind)
            KIND_BOX:    n_hit = flg_f.box_hit;
            KIND_CYL:    n_hit = cyl_hit;
            KIND_SPHERE: n_hit = flg_f.sph_hit;
            KIND_WALL:   n_hit = flg_f.wall_hit;
            default:     n_hit = 1'b1;
        endcase
    end

    logic r_out_vld, r_out_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit <= n_hit;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.on_surface = r_out_hit;

endmodule

// ===== hdl/pvst_check.sv =====
module pvst_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_on_surface,
    input logic i_cfg_ready
);

    // a held response stays put until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_on_surface))
        else $error("response dropped or changed while stalled");

    // requests are taken whenever the output slot is free
    a_req_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid || i_rsp_ready |-> i_req_ready)
        else $error("request stalled with free output");

    // ready low only while a response waits
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_rsp_valid && !i_rsp_ready)
        else $error("ready low without backpressure");

    // no response right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config port not ready");

endmodule

bind point_on_volume_surface_test_core pvst_check u_pvst_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_on_surface (o_rsp.on_surface),
    .i_cfg_ready      (i_cfg.ready)
);
